// File: rtl/v3alu_pkg.sv
// v3alu_pkg: opcodes and the opcode field width of the vector ALU.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package v3alu_pkg;

  localparam int OP_W = 4;

  localparam logic [OP_W-1:0] OP_ADD   = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB   = 4'd1;
  localparam logic [OP_W-1:0] OP_SCALE = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV   = 4'd3;
  localparam logic [OP_W-1:0] OP_NEG   = 4'd4;
  localparam logic [OP_W-1:0] OP_DOT   = 4'd5;
  localparam logic [OP_W-1:0] OP_CROSS = 4'd6;
  localparam logic [OP_W-1:0] OP_MAG2  = 4'd7;
  localparam logic [OP_W-1:0] OP_MAG   = 4'd8;
  localparam logic [OP_W-1:0] OP_NORM  = 4'd9;

endpackage

`default_nettype wire

// File: rtl/v3alu_if.sv
// v3alu_in_if / v3alu_out_if: valid/ready channels for operand and result words.
// Depends on v3alu_pkg for the opcode width.
`timescale 1ns / 1ps
`default_nettype none

interface v3alu_in_if import v3alu_pkg::*; #(parameter int WORD_BITS = 32) ();
  logic                        valid;
  logic                        ready;
  logic [OP_W-1:0]             opcode;
  logic signed [WORD_BITS-1:0] a_x;
  logic signed [WORD_BITS-1:0] a_y;
  logic signed [WORD_BITS-1:0] a_z;
  logic signed [WORD_BITS-1:0] b_x;
  logic signed [WORD_BITS-1:0] b_y;
  logic signed [WORD_BITS-1:0] b_z;
  logic signed [WORD_BITS-1:0] scalar_in;

  modport source (output valid, opcode, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
                  input ready);
  modport sink   (input valid, opcode, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
                  output ready);
endinterface

interface v3alu_out_if #(parameter int WORD_BITS = 32) ();
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] r_x;
  logic signed [WORD_BITS-1:0] r_y;
  logic signed [WORD_BITS-1:0] r_z;
  logic signed [WORD_BITS-1:0] r_scalar;
  logic                        div_error;

  modport source (output valid, r_x, r_y, r_z, r_scalar, div_error, input ready);
  modport sink   (input valid, r_x, r_y, r_z, r_scalar, div_error, output ready);
endinterface

`default_nettype wire

// File: rtl/v3alu_mul.sv
// v3alu_mul: operand select, six multipliers and the sum/saturate stage (3 stages).
// Depends on v3alu_pkg for opcodes.
`timescale 1ns / 1ps
`default_nettype none

module v3alu_mul import v3alu_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     vin,
  input  wire logic [OP_W-1:0]          op_in,
  input  wire logic [2:0][W-1:0]        a_in,
  input  wire logic [2:0][W-1:0]        b_in,
  input  wire logic [W-1:0]             s_in,
  output logic                          vout,
  output logic [OP_W-1:0]               op_out,
  output logic [2:0][W-1:0]             r_out,
  output logic [W-1:0]                  rs_out,
  output logic [2:0]                    a_neg_out,
  output logic [2:0][W-1:0]             a_mag_out,
  output logic [W-1:0]                  s_mag_out,
  output logic                          s_neg_out,
  output logic [2*W-1:0]                sq_out
);

  localparam int SUMW = 2 * W + 2;
  localparam logic signed [SUMW-1:0] SMAX = {{(SUMW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SUMW-1:0] SMIN = {{(SUMW-W+1){1'b1}}, {(W-1){1'b0}}};

  function automatic logic [W-1:0] sat_fn(input logic signed [SUMW-1:0] v);
    logic [W-1:0] res;
    if (v > SMAX) res = SMAX[W-1:0];
    else if (v < SMIN) res = SMIN[W-1:0];
    else res = v[W-1:0];
    return res;
  endfunction

  // stage 1: operand select, add/sub/negate and magnitudes
  logic                  v1_r;
  logic [OP_W-1:0]       op1_r;
  logic signed [W-1:0]   lft1_r [3];
  logic signed [W-1:0]   rgt1_r [6];
  logic signed [W:0]     as1_r [3];
  logic [2:0]            an1_r;
  logic [W-1:0]          am1_r [3];
  logic [W-1:0]          sm1_r;
  logic                  sn1_r;

  logic signed [W-1:0]   rgt_nxt [6];
  logic signed [W:0]     as_nxt [3];
  logic [W-1:0]          am_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rgt_nxt[i+3] = b_in[(i+2)%3];
      case (op_in)
        OP_SCALE: rgt_nxt[i] = s_in;
        OP_DOT:   rgt_nxt[i] = b_in[i];
        OP_CROSS: rgt_nxt[i] = b_in[(i+1)%3];
        default:  rgt_nxt[i] = a_in[i];
      endcase
      case (op_in)
        OP_ADD:  as_nxt[i] = {a_in[i][W-1], a_in[i]} + {b_in[i][W-1], b_in[i]};
        OP_SUB:  as_nxt[i] = {a_in[i][W-1], a_in[i]} - {b_in[i][W-1], b_in[i]};
        OP_NEG:  as_nxt[i] = -{a_in[i][W-1], a_in[i]};
        default: as_nxt[i] = '0;
      endcase
      am_nxt[i] = a_in[i][W-1] ? (~a_in[i] + W'(1)) : a_in[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= op_in;
      for (int i = 0; i < 3; i++) begin
        lft1_r[i] <= a_in[i];
        as1_r[i]  <= as_nxt[i];
        am1_r[i]  <= am_nxt[i];
        an1_r[i]  <= a_in[i][W-1];
      end
      for (int i = 0; i < 6; i++) rgt1_r[i] <= rgt_nxt[i];
      sm1_r <= s_in[W-1] ? (~s_in + W'(1)) : s_in;
      sn1_r <= s_in[W-1];
    end
  end

  // stage 2: products
  logic                    v2_r;
  logic [OP_W-1:0]         op2_r;
  logic signed [2*W-1:0]   p2_r [6];
  logic signed [W:0]       as2_r [3];
  logic [2:0]              an2_r;
  logic [W-1:0]            am2_r [3];
  logic [W-1:0]            sm2_r;
  logic                    sn2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r <= op1_r;
      for (int i = 0; i < 6; i++) p2_r[i] <= lft1_r[i%3] * rgt1_r[i];
      for (int i = 0; i < 3; i++) begin
        as2_r[i] <= as1_r[i];
        am2_r[i] <= am1_r[i];
      end
      an2_r <= an1_r;
      sm2_r <= sm1_r;
      sn2_r <= sn1_r;
    end
  end

  // stage 3: sums, shift, saturate
  logic signed [SUMW-1:0] sum3;
  logic signed [SUMW-1:0] sum3_sh;
  logic signed [SUMW-1:0] term [3];
  logic [2:0][W-1:0]      r_nxt;
  logic [W-1:0]           rs_nxt;

  always_comb begin
    sum3    = SUMW'(p2_r[0]) + SUMW'(p2_r[1]) + SUMW'(p2_r[2]);
    sum3_sh = sum3 >>> F;
    rs_nxt  = (op2_r == OP_DOT || op2_r == OP_MAG2) ? sat_fn(sum3_sh) : '0;
    for (int i = 0; i < 3; i++) begin
      case (op2_r)
        OP_SCALE: term[i] = SUMW'(p2_r[i]) >>> F;
        OP_CROSS: term[i] = (SUMW'(p2_r[(i+1)%3]) - SUMW'(p2_r[((i+2)%3)+3])) >>> F;
        default:  term[i] = SUMW'(as2_r[i]);
      endcase
      r_nxt[i] = sat_fn(term[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_out    <= op2_r;
      r_out     <= r_nxt;
      rs_out    <= rs_nxt;
      a_neg_out <= an2_r;
      for (int i = 0; i < 3; i++) a_mag_out[i] <= am2_r[i];
      s_mag_out <= sm2_r;
      s_neg_out <= sn2_r;
      sq_out    <= sum3[2*W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/v3alu_sqrt.sv
// v3alu_sqrt: floor square root, one root bit per pipeline stage, with sideband.
// Depends on v3alu_pkg (imported for consistency; no opcodes used).
`timescale 1ns / 1ps
`default_nettype none

module v3alu_sqrt import v3alu_pkg::*; #(
  parameter int W   = 32,
  parameter int SBW = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             vin,
  input  wire logic [2*W-1:0]   n_in,
  input  wire logic [SBW-1:0]   sb_in,
  output logic                  vout,
  output logic [W-1:0]          root_out,
  output logic [SBW-1:0]        sb_out
);

  logic             v_r    [W];
  logic [2*W-1:0]   rem_r  [W];
  logic [W-1:0]     root_r [W];
  logic [SBW-1:0]   sb_r   [W];

  for (genvar k = 0; k < W; k++) begin : g_stg
    localparam int B = W - 1 - k;
    logic             v_prev;
    logic [2*W-1:0]   rem_prev;
    logic [W-1:0]     root_prev;
    logic [SBW-1:0]   sb_prev;
    logic [2*W:0]     trial;
    logic             ge;
    logic [2*W-1:0]   rem_nxt;
    logic [W-1:0]     root_nxt;

    if (k == 0) begin : g_first
      assign v_prev    = vin;
      assign rem_prev  = n_in;
      assign root_prev = '0;
      assign sb_prev   = sb_in;
    end else begin : g_next
      assign v_prev    = v_r[k-1];
      assign rem_prev  = rem_r[k-1];
      assign root_prev = root_r[k-1];
      assign sb_prev   = sb_r[k-1];
    end

    always_comb begin
      trial    = ((2*W+1)'(root_prev) << (B + 1)) + ((2*W+1)'(1) << (2 * B));
      ge       = {1'b0, rem_prev} >= trial;
      rem_nxt  = ge ? (rem_prev - trial[2*W-1:0]) : rem_prev;
      root_nxt = root_prev | ({{(W-1){1'b0}}, ge} << B);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        sb_r[k]   <= sb_prev;
      end
    end
  end

  assign vout     = v_r[W-1];
  assign root_out = root_r[W-1];
  assign sb_out   = sb_r[W-1];

endmodule

`default_nettype wire

// File: rtl/v3alu_div.sv
// v3alu_div: three-lane restoring divider, (a << F) / d, one quotient bit per stage.
// Depends on v3alu_pkg (imported for consistency; no opcodes used).
`timescale 1ns / 1ps
`default_nettype none

module v3alu_div import v3alu_pkg::*; #(
  parameter int W   = 32,
  parameter int F   = 16,
  parameter int SBW = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  vin,
  input  wire logic [2:0][W-1:0]     a_mag_in,
  input  wire logic [W-1:0]          d_in,
  input  wire logic [SBW-1:0]        sb_in,
  output logic                       vout,
  output logic [2:0][W+F-1:0]        q_out,
  output logic [SBW-1:0]             sb_out
);

  localparam int NW = W + F;

  logic                  v_r  [NW];
  logic [2:0][W-1:0]     am_r [NW];
  logic [2:0][W-1:0]     rem_r [NW];
  logic [2:0][NW-1:0]    q_r  [NW];
  logic [W-1:0]          d_r  [NW];
  logic [SBW-1:0]        sb_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stg
    localparam int J = NW - 1 - k;
    logic                v_prev;
    logic [2:0][W-1:0]   am_prev;
    logic [2:0][W-1:0]   rem_prev;
    logic [2:0][NW-1:0]  q_prev;
    logic [W-1:0]        d_prev;
    logic [SBW-1:0]      sb_prev;
    logic [2:0][W-1:0]   rem_nxt;
    logic [2:0][NW-1:0]  q_nxt;

    if (k == 0) begin : g_first
      assign v_prev   = vin;
      assign am_prev  = a_mag_in;
      assign rem_prev = '0;
      assign q_prev   = '0;
      assign d_prev   = d_in;
      assign sb_prev  = sb_in;
    end else begin : g_next
      assign v_prev   = v_r[k-1];
      assign am_prev  = am_r[k-1];
      assign rem_prev = rem_r[k-1];
      assign q_prev   = q_r[k-1];
      assign d_prev   = d_r[k-1];
      assign sb_prev  = sb_r[k-1];
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic          nbit;
      logic [W:0]    trial;
      logic [W:0]    diff;
      logic          ge;

      if (J >= F) begin : g_abit
        assign nbit = am_prev[i][J-F];
      end else begin : g_zbit
        assign nbit = 1'b0;
      end

      always_comb begin
        trial      = {rem_prev[i], nbit};
        diff       = trial - {1'b0, d_prev};
        ge         = trial >= {1'b0, d_prev};
        rem_nxt[i] = ge ? diff[W-1:0] : trial[W-1:0];
        q_nxt[i]   = q_prev[i] | ({{(NW-1){1'b0}}, ge} << J);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        am_r[k]  <= am_prev;
        rem_r[k] <= rem_nxt;
        q_r[k]   <= q_nxt;
        d_r[k]   <= d_prev;
        sb_r[k]  <= sb_prev;
      end
    end
  end

  assign vout   = v_r[NW-1];
  assign q_out  = q_r[NW-1];
  assign sb_out = sb_r[NW-1];

endmodule

`default_nettype wire

// File: rtl/vector3_alu.sv
// vector3_alu: top level of the three-component fixed-point vector ALU.
// Depends on v3alu_pkg, v3alu_if, v3alu_mul, v3alu_sqrt and v3alu_div.
//
// Takes one word per cycle while the result side is not stalled and returns
// one result word per input word, in order. Every opcode goes through the
// same pipeline: 3 multiply/sum stages, WORD_BITS square-root stages,
// WORD_BITS+FRAC_BITS divide stages and one output register. The length is
// set by the bit-per-stage square root and divider. A stall on the result side
// holds the whole pipeline; no reset pass or idle time is needed between words.
`timescale 1ns / 1ps
`default_nettype none

module vector3_alu import v3alu_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  v3alu_in_if.sink       in_ch,
  v3alu_out_if.source    out_ch
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int NW = W + F;
  localparam int QW = NW + 1;
  localparam logic signed [QW-1:0] QMAX = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [QW-1:0] QMIN = {{(QW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [2:0][W-1:0] r;
    logic [W-1:0]      rs;
    logic [2:0]        a_neg;
    logic [2:0][W-1:0] a_mag;
    logic [W-1:0]      s_mag;
    logic              s_neg;
  } sb1_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [2:0][W-1:0] r;
    logic [W-1:0]      rs;
    logic [2:0]        a_neg;
    logic              s_neg;
    logic [W-1:0]      m;
    logic              err;
  } sb2_t;

  function automatic logic [W-1:0] sat_q(input logic signed [QW-1:0] v);
    logic [W-1:0] res;
    if (v > QMAX) res = QMAX[W-1:0];
    else if (v < QMIN) res = QMIN[W-1:0];
    else res = v[W-1:0];
    return res;
  endfunction

  logic en;
  logic out_valid_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // multiply and sum
  logic              mv;
  logic [OP_W-1:0]   m_op;
  logic [2:0][W-1:0] m_r;
  logic [W-1:0]      m_rs;
  logic [2:0]        m_an;
  logic [2:0][W-1:0] m_am;
  logic [W-1:0]      m_sm;
  logic              m_sn;
  logic [2*W-1:0]    m_sq;
  logic [2:0][W-1:0] a_in;
  logic [2:0][W-1:0] b_in;

  assign a_in = {in_ch.a_z, in_ch.a_y, in_ch.a_x};
  assign b_in = {in_ch.b_z, in_ch.b_y, in_ch.b_x};

  v3alu_mul #(.W(W), .F(F)) u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .vin       (in_ch.valid && en),
    .op_in     (in_ch.opcode),
    .a_in      (a_in),
    .b_in      (b_in),
    .s_in      (in_ch.scalar_in),
    .vout      (mv),
    .op_out    (m_op),
    .r_out     (m_r),
    .rs_out    (m_rs),
    .a_neg_out (m_an),
    .a_mag_out (m_am),
    .s_mag_out (m_sm),
    .s_neg_out (m_sn),
    .sq_out    (m_sq)
  );

  // square root
  sb1_t           sb1_in;
  sb1_t           sb1_out;
  logic           sv;
  logic [W-1:0]   root;

  always_comb begin
    sb1_in.op    = m_op;
    sb1_in.r     = m_r;
    sb1_in.rs    = m_rs;
    sb1_in.a_neg = m_an;
    sb1_in.a_mag = m_am;
    sb1_in.s_mag = m_sm;
    sb1_in.s_neg = m_sn;
  end

  v3alu_sqrt #(.W(W), .SBW($bits(sb1_t))) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vin      (mv),
    .n_in     (m_sq),
    .sb_in    (sb1_in),
    .vout     (sv),
    .root_out (root),
    .sb_out   (sb1_out)
  );

  // divide
  sb2_t            sb2_in;
  sb2_t            sb2_out;
  logic [W-1:0]    dvsr;
  logic            dv;
  logic [2:0][NW-1:0] quo;

  always_comb begin
    dvsr         = (sb1_out.op == OP_NORM) ? root : sb1_out.s_mag;
    sb2_in.op    = sb1_out.op;
    sb2_in.r     = sb1_out.r;
    sb2_in.rs    = sb1_out.rs;
    sb2_in.a_neg = sb1_out.a_neg;
    sb2_in.s_neg = sb1_out.s_neg;
    sb2_in.m     = root;
    sb2_in.err   = (sb1_out.op == OP_DIV || sb1_out.op == OP_NORM) && (dvsr == '0);
  end

  v3alu_div #(.W(W), .F(F), .SBW($bits(sb2_t))) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vin      (sv),
    .a_mag_in (sb1_out.a_mag),
    .d_in     (dvsr),
    .sb_in    (sb2_in),
    .vout     (dv),
    .q_out    (quo),
    .sb_out   (sb2_out)
  );

  // result select
  logic [2:0][W-1:0] r_nxt;
  logic [W-1:0]      rs_nxt;
  logic              err_nxt;
  logic [2:0][W-1:0] qs;
  logic [W-1:0]      msat;
  logic signed [QW-1:0] qv [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qv[i] = $signed({1'b0, quo[i]});
      if (sb2_out.a_neg[i] ^ (sb2_out.op == OP_DIV && sb2_out.s_neg)) qv[i] = -qv[i];
      qs[i] = sat_q(qv[i]);
    end
    msat    = sb2_out.m[W-1] ? WMAX : sb2_out.m;
    r_nxt   = sb2_out.r;
    rs_nxt  = sb2_out.rs;
    err_nxt = sb2_out.err;
    case (sb2_out.op)
      OP_DIV: begin
        r_nxt  = sb2_out.err ? '0 : qs;
        rs_nxt = '0;
      end
      OP_MAG: begin
        rs_nxt = msat;
      end
      OP_NORM: begin
        r_nxt  = sb2_out.err ? '0 : qs;
        rs_nxt = sb2_out.err ? '0 : msat;
      end
      default: begin
        err_nxt = 1'b0;
      end
    endcase
  end

  logic [2:0][W-1:0] r_out_r;
  logic [W-1:0]      rs_out_r;
  logic              err_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_out_r   <= r_nxt;
      rs_out_r  <= rs_nxt;
      err_out_r <= err_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.r_x       = r_out_r[0];
  assign out_ch.r_y       = r_out_r[1];
  assign out_ch.r_z       = r_out_r[2];
  assign out_ch.r_scalar  = rs_out_r;
  assign out_ch.div_error = err_out_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && err_out_r |-> r_out_r == '0 && rs_out_r == '0)
    else $error("error word carries nonzero data");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while result stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(r_out_r) && $stable(rs_out_r))
    else $error("output register changed under stall");

endmodule

`default_nettype wire

// File: sim/vector3_alu_test.sv
// vector3_alu_test: self-checking testbench for the Q16.16 vector ALU.
// Depends on rtl/v3alu_pkg.sv, rtl/v3alu_if.sv and the vector3_alu RTL.
// Random and directed words go in; each result word is checked against a local predictor.
`timescale 1ns / 1ps

module vector3_alu_test;
  import v3alu_pkg::*;

  localparam int WB = 32;
  localparam int FB = 16;
  localparam logic signed [31:0] WMAX = 32'sh7fffffff;
  localparam logic signed [31:0] WMIN = 32'sh80000000;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic signed [31:0] a [3];
    logic signed [31:0] b [3];
    logic signed [31:0] s;
    bit                 drain;
  } operand_t;

  typedef struct {
    logic signed [31:0] r [3];
    logic signed [31:0] rs;
    logic               err;
  } result_t;

  logic clk;
  logic rst_n;

  v3alu_in_if  #(.WORD_BITS(WB)) in_ch ();
  v3alu_out_if #(.WORD_BITS(WB)) out_ch ();

  vector3_alu #(.WORD_BITS(WB), .FRAC_BITS(FB)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  operand_t pending_ops [$];
  result_t  expected_results [$];
  int       error_count = 0;
  int       send_gap = 0;
  int       recv_stall = 0;
  bit       burst = 0;

  function automatic logic signed [31:0] clamp(wide_t v);
    if (v > wide_t'(WMAX)) return WMAX;
    if (v < wide_t'(WMIN)) return WMIN;
    return v[31:0];
  endfunction

  function automatic wide_t floor_sqrt(wide_t n);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int i = 40; i >= 0; i--) begin
      c = r | (128'd1 << i);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] fixed_div(logic signed [31:0] x, wide_t d);
    wide_t n;
    n = wide_t'(x) <<< FB;
    return clamp(n / d);
  endfunction

  function automatic result_t vector_result(operand_t t);
    result_t res;
    wide_t   a [3];
    wide_t   b [3];
    wide_t   s;
    wide_t   acc;
    wide_t   m;
    int      j;
    int      k;
    res.r = '{0, 0, 0};
    res.rs = 0;
    res.err = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = t.a[i];
      b[i] = t.b[i];
    end
    s = t.s;
    acc = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    case (t.op)
      OP_ADD: for (int i = 0; i < 3; i++) res.r[i] = clamp(a[i] + b[i]);
      OP_SUB: for (int i = 0; i < 3; i++) res.r[i] = clamp(a[i] - b[i]);
      OP_SCALE: for (int i = 0; i < 3; i++) res.r[i] = clamp((a[i] * s) >>> FB);
      OP_DIV: begin
        if (s == 0) res.err = 1;
        else for (int i = 0; i < 3; i++) res.r[i] = fixed_div(t.a[i], s);
      end
      OP_NEG: for (int i = 0; i < 3; i++) res.r[i] = clamp(-a[i]);
      OP_DOT: res.rs = clamp((a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> FB);
      OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          j = (i + 1) % 3;
          k = (i + 2) % 3;
          res.r[i] = clamp((a[j] * b[k] - a[k] * b[j]) >>> FB);
        end
      end
      OP_MAG2: res.rs = clamp(acc >>> FB);
      OP_MAG: res.rs = clamp(floor_sqrt(acc));
      OP_NORM: begin
        m = floor_sqrt(acc);
        if (m == 0) res.err = 1;
        else begin
          for (int i = 0; i < 3; i++) res.r[i] = fixed_div(t.a[i], m);
          res.rs = clamp(m);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic signed [31:0] rand_component();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return $urandom_range(0, 32'h001fffff) - 32'sh00100000;
      3: return $urandom_range(0, 32'h01ffffff) - 32'sh01000000;
      4: begin
        case ($urandom_range(0, 4))
          0: return WMAX;
          1: return WMIN;
          2: return 0;
          3: return 1;
          default: return -1;
        endcase
      end
      default: return $urandom_range(0, 32'h0003ffff) - 32'sh00020000;
    endcase
  endfunction

  function automatic operand_t make_op(logic [OP_W-1:0] op, logic signed [31:0] ax,
                                       logic signed [31:0] ay, logic signed [31:0] az,
                                       logic signed [31:0] bx, logic signed [31:0] by,
                                       logic signed [31:0] bz, logic signed [31:0] s);
    operand_t t;
    t.op = op;
    t.a = '{ax, ay, az};
    t.b = '{bx, by, bz};
    t.s = s;
    t.drain = 0;
    return t;
  endfunction

  task automatic report(string field, logic signed [31:0] got, logic signed [31:0] want);
    $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    error_count++;
  endtask

  initial begin
    clk = 0;
    rst_n = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    operand_t t;
    pending_ops.push_back(make_op(OP_ADD, WMAX, WMIN, 1, WMAX, WMIN, -1, 0));
    pending_ops.push_back(make_op(OP_SUB, WMIN, WMAX, 0, WMAX, WMIN, 0, 0));
    pending_ops.push_back(make_op(OP_SCALE, WMAX, WMIN, 32'sh00010000, 0, 0, 0, WMAX));
    pending_ops.push_back(make_op(OP_SCALE, WMIN, -3, 5, 0, 0, 0, -32'sh00010000));
    pending_ops.push_back(make_op(OP_DIV, 32'sh00050000, -7, WMAX, 0, 0, 0, 0));
    pending_ops.push_back(make_op(OP_DIV, WMIN, WMAX, -32'sh00030000, 0, 0, 0, 1));
    pending_ops.push_back(make_op(OP_DIV, 32'sh00070000, -32'sh00070000, 3, 0, 0, 0,
                                  -32'sh00020000));
    pending_ops.push_back(make_op(OP_NEG, WMIN, WMAX, 0, 0, 0, 0, 0));
    pending_ops.push_back(make_op(OP_DOT, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, 0));
    pending_ops.push_back(make_op(OP_DOT, WMIN, WMIN, WMIN, WMAX, WMAX, WMAX, 0));
    pending_ops.push_back(make_op(OP_CROSS, WMIN, WMAX, 1, WMAX, WMIN, -1, 0));
    pending_ops.push_back(make_op(OP_CROSS, 32'sh00010000, 0, 0, 0, 32'sh00010000, 0, 0));
    pending_ops.push_back(make_op(OP_MAG2, WMIN, WMIN, WMIN, 0, 0, 0, 0));
    pending_ops.push_back(make_op(OP_MAG2, 32'sh00020000, -1, 0, 0, 0, 0, 0));
    pending_ops.push_back(make_op(OP_MAG, WMIN, WMIN, WMIN, 0, 0, 0, 0));
    pending_ops.push_back(make_op(OP_MAG, 32'sh00030000, 32'sh00040000, 0, 0, 0, 0, 0));
    pending_ops.push_back(make_op(OP_NORM, 0, 0, 0, 1, 2, 3, 4));
    pending_ops.push_back(make_op(OP_NORM, 1, 0, 0, 0, 0, 0, 0));
    pending_ops.push_back(make_op(OP_NORM, WMIN, WMAX, 5, 0, 0, 0, 0));
    pending_ops.push_back(make_op(OP_NORM, 32'sh00030000, -32'sh00040000, 0, 0, 0, 0, 0));
    pending_ops.push_back(make_op(4'd10, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX));
    pending_ops.push_back(make_op(4'd15, -1, -1, -1, -1, -1, -1, 0));
    for (int n = 0; n < 1330; n++) begin
      t.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                          : 4'($urandom_range(0, 9));
      for (int i = 0; i < 3; i++) begin
        t.a[i] = rand_component();
        t.b[i] = rand_component();
      end
      t.s = ($urandom_range(0, 15) == 0) ? 0 : rand_component();
      if (t.op == OP_NORM && $urandom_range(0, 9) == 0) t.a = '{0, 0, 0};
      t.drain = (n == 600 || n == 1100);
      pending_ops.push_back(t);
    end
  end

  // driver: hold the word until accepted, then wait the drawn gap
  always @(posedge clk) begin
    operand_t t;
    if (!rst_n) begin
      in_ch.valid <= 0;
      in_ch.opcode <= '0;
      in_ch.a_x <= '0;
      in_ch.a_y <= '0;
      in_ch.a_z <= '0;
      in_ch.b_x <= '0;
      in_ch.b_y <= '0;
      in_ch.b_z <= '0;
      in_ch.scalar_in <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        t.op = in_ch.opcode;
        t.a = '{in_ch.a_x, in_ch.a_y, in_ch.a_z};
        t.b = '{in_ch.b_x, in_ch.b_y, in_ch.b_z};
        t.s = in_ch.scalar_in;
        expected_results.push_back(vector_result(t));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_ch.valid <= 0;
        end else if (pending_ops.size() > 0 &&
                     !(pending_ops[0].drain &&
                       (expected_results.size() > 0 || in_ch.valid))) begin
          t = pending_ops.pop_front();
          in_ch.valid <= 1;
          in_ch.opcode <= t.op;
          in_ch.a_x <= t.a[0];
          in_ch.a_y <= t.a[1];
          in_ch.a_z <= t.a[2];
          in_ch.b_x <= t.b[0];
          in_ch.b_y <= t.b[1];
          in_ch.b_z <= t.b[2];
          in_ch.scalar_in <= t.s;
          if ($urandom_range(0, 99) < 2) burst = !burst;
          send_gap <= burst ? 0 : $urandom_range(0, 11);
        end else begin
          in_ch.valid <= 0;
        end
      end
    end
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("unexpected result word");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.r_x !== want.r[0]) report("r_x", out_ch.r_x, want.r[0]);
          if (out_ch.r_y !== want.r[1]) report("r_y", out_ch.r_y, want.r[1]);
          if (out_ch.r_z !== want.r[2]) report("r_z", out_ch.r_z, want.r[2]);
          if (out_ch.r_scalar !== want.rs) report("r_scalar", out_ch.r_scalar, want.rs);
          if (out_ch.div_error !== want.err)
            report("div_error", 32'(out_ch.div_error), 32'(want.err));
        end
        recv_stall = burst ? 0 : $urandom_range(0, 11);
      end
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    wait (pending_ops.size() == 0 && !in_ch.valid);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("vector3_alu test passed");
    end else begin
      $display("vector3_alu test failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("vector3_alu test failed");
    $finish;
  end

endmodule
